### rtl/core/cgov_pkg.sv
`default_nettype none

package cgov_pkg;

  // Default build sizes
  localparam int unsigned CGOV_CORE_COUNT = 8;
  localparam int unsigned CGOV_HIST_MAX   = 16;

  // Field widths
  localparam int unsigned LOAD_W     = 10;
  localparam int unsigned PEAK_W     = 7;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned TIME_W     = 48;
  localparam int unsigned HOLD_W     = 40;
  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned HLEN_W     = 5;
  localparam int unsigned ROW_W      = 3;
  localparam int unsigned TBL_W      = 9;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 40;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_UP   = 2'd1,
    ACT_DOWN = 2'd2
  } action_e;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TOUCH  = 1'b1;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_ENABLED    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ONLINE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ONLINE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOOST_CNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_LANE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOOST_HOLD = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HIST_LEN   = 3'd6;

  // Reset values
  localparam int unsigned           MAX_ONLINE_RESET = 8;
  localparam int unsigned           HIST_LEN_RESET   = 10;
  localparam logic [CNT_W-1:0]      MIN_ONLINE_RESET = 4'd1;
  localparam logic [CNT_W-1:0]      BOOST_CNT_RESET  = 4'd4;
  localparam logic [LEVEL_W-1:0]    FAST_LANE_RESET  = 8'd99;
  localparam logic [HOLD_W-1:0]     BOOST_HOLD_RESET = 40'd2500000;

  // Least spacing between two touch boosts
  localparam logic [TIME_W-1:0]     TOUCH_GAP_US     = 48'd150000;

  // Threshold table, one row per core count; a zero upper level ends it
  function automatic logic [TBL_W-1:0] level_up(input logic [ROW_W-1:0] row);
    logic [TBL_W-1:0] lvl;
    case (row)
      3'd0:    lvl = 9'd400;
      3'd1:    lvl = 9'd65;
      3'd2:    lvl = 9'd120;
      3'd3:    lvl = 9'd190;
      3'd4:    lvl = 9'd410;
      default: lvl = 9'd0;
    endcase
    return lvl;
  endfunction

  function automatic logic [TBL_W-1:0] level_down(input logic [ROW_W-1:0] row);
    logic [TBL_W-1:0] lvl;
    case (row)
      3'd2:    lvl = 9'd50;
      3'd3:    lvl = 9'd100;
      3'd4:    lvl = 9'd170;
      default: lvl = 9'd0;
    endcase
    return lvl;
  endfunction

endpackage

`default_nettype wire

### rtl/core/cgov_ram.sv
`default_nettype none

module cgov_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/core/core_count_governor_core.sv
`default_nettype none

// Core count governor. Each input beat is either a load sample (kind 0) or a
// touch event (kind 1); each gives exactly one result beat with an action
// (none, bring up, take down), a target core count and the averaged summed
// load. A sample is written into a ring of recent loads, the ring is summed
// one entry per cycle from the read port of the history RAM, and the sum
// is divided by history_len in a restoring divider that retires one quotient
// bit per cycle over SUM_W bits, where SUM_W is 10 + log2(HIST_MAX), 14 at
// the default sizes. The table walk then checks one threshold row per cycle.
// A sample with a history of one skips the ring and the divider. The input
// stalls while a beat is in work; a finished result sits in an output register,
// so a new beat may be taken while the previous result still waits downstream.
// Reset clears the history through a valid bit per ring entry, so there is no
// clearing pass. Configuration writes are taken whenever the block is idle.
module core_count_governor_core
  import cgov_pkg::*;
#(
  parameter int unsigned CORE_COUNT = CGOV_CORE_COUNT,
  parameter int unsigned HIST_MAX   = CGOV_HIST_MAX
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write channel
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // input channel
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  kind_i,
  input  wire logic [LOAD_W-1:0]     total_load_i,
  input  wire logic [PEAK_W-1:0]     peak_load_i,
  input  wire logic [CNT_W-1:0]      cores_online_i,
  input  wire logic [TIME_W-1:0]     now_us_i,
  // result channel
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [1:0]                 action_o,
  output logic [CNT_W-1:0]           target_cores_o,
  output logic [LOAD_W-1:0]          avg_load_o
);

  // Widths that follow from the build sizes
  localparam int unsigned POS_W  = (HIST_MAX > 1) ? $clog2(HIST_MAX) : 1;
  localparam int unsigned CMP_W  = ((POS_W > HLEN_W) ? POS_W : HLEN_W) + 1;
  localparam int unsigned SUM_W  = LOAD_W + $clog2(HIST_MAX);
  localparam int unsigned DCNT_W = $clog2(SUM_W + 1);

  localparam logic [CNT_W:0]     CORE_LIMIT = (CNT_W + 1)'(CORE_COUNT);
  localparam logic [CMP_W-1:0]   HIST_LIMIT = CMP_W'(HIST_MAX);
  localparam logic [CNT_W-1:0]   MAX_RST    = (CORE_COUNT < MAX_ONLINE_RESET) ?
                                              CNT_W'(CORE_COUNT) :
                                              CNT_W'(MAX_ONLINE_RESET);
  localparam logic [HLEN_W-1:0]  HLEN_RST   = (HIST_MAX < HIST_LEN_RESET) ?
                                              HLEN_W'(HIST_MAX) :
                                              HLEN_W'(HIST_LEN_RESET);
  localparam logic [DCNT_W-1:0]  DIV_STEPS  = DCNT_W'(SUM_W);

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_TOUCH  = 3'd1;
  localparam logic [2:0] ST_SAMPLE = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_TABLE  = 3'd5;
  localparam logic [2:0] ST_DECIDE = 3'd6;
  localparam logic [2:0] ST_EMIT   = 3'd7;

  logic [2:0] state_q, state_d;

  // Configuration registers
  logic                en_q;
  logic [CNT_W-1:0]    min_q;
  logic [CNT_W-1:0]    max_q;
  logic [CNT_W-1:0]    boost_q;
  logic [LEVEL_W-1:0]  flane_q;
  logic [HOLD_W-1:0]   hold_us_q;
  logic [HLEN_W-1:0]   hlen_q;

  // Latched input beat
  logic                kind_q;
  logic [LOAD_W-1:0]   total_q;
  logic [PEAK_W-1:0]   peak_q;
  logic [CNT_W-1:0]    online_q;
  logic [TIME_W-1:0]   now_q;

  // Governor state
  logic [POS_W-1:0]    pos_q;
  logic [LOAD_W-1:0]   avg_q;
  logic [TIME_W-1:0]   last_touch_q;
  logic [TIME_W-1:0]   last_boost_q;
  logic [HIST_MAX-1:0] ring_vld_q;

  // Working registers
  logic [CMP_W-1:0]    idx_q;
  logic                pend_q;
  logic                rd_vld_q;
  logic [SUM_W-1:0]    acc_q;
  logic [HLEN_W-1:0]   rem_q;
  logic [DCNT_W-1:0]   dcnt_q;
  logic [ROW_W-1:0]    row_q;
  logic [ROW_W-1:0]    tbl_tgt_q;
  logic                hold_q;
  action_e             res_act_q;
  logic [CNT_W-1:0]    res_tgt_q;

  // Output register
  logic                out_vld_q;
  action_e             out_act_q;
  logic [CNT_W-1:0]    out_tgt_q;
  logic [LOAD_W-1:0]   out_avg_q;

  logic in_fire;
  logic cfg_we;
  logic emit_go;

  assign cfg_ready_o = (state_q == ST_IDLE);
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign emit_go     = (state_q == ST_EMIT) && (!out_vld_q || !out_stall_i);

  // ---------------------------------------------------------------------------
  // Ring pointer handling: restart a stale position, then advance with wrap
  // ---------------------------------------------------------------------------
  logic [CMP_W-1:0] len_ext;
  logic [POS_W-1:0] pos_eff;
  logic [CMP_W-1:0] pos_inc;
  logic [POS_W-1:0] pos_nxt;
  logic             hist_on;

  assign len_ext = CMP_W'(hlen_q);
  assign pos_eff = (CMP_W'(pos_q) >= len_ext) ? '0 : pos_q;
  assign pos_inc = CMP_W'(pos_eff) + CMP_W'(1);
  assign pos_nxt = (pos_inc >= len_ext) ? '0 : pos_inc[POS_W-1:0];
  assign hist_on = (hlen_q > HLEN_W'(1));

  // ---------------------------------------------------------------------------
  // History RAM: one write of the new sample, then one read per cycle
  // ---------------------------------------------------------------------------
  logic              ram_we;
  logic [POS_W-1:0]  ram_raddr;
  logic [LOAD_W-1:0] ram_rdata;
  logic              rd_en;
  logic [LOAD_W-1:0] rd_load;

  assign ram_we    = (state_q == ST_SAMPLE) && hist_on;
  assign rd_en     = (state_q == ST_READ) && (idx_q < len_ext);
  assign ram_raddr = idx_q[POS_W-1:0];
  // An entry never written since reset reads as zero
  assign rd_load   = rd_vld_q ? ram_rdata : '0;

  cgov_ram #(
    .WIDTH (LOAD_W),
    .DEPTH (HIST_MAX),
    .ADDR_W(POS_W)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(pos_eff),
    .wdata_i(total_q),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Divider step: shift one dividend bit into the remainder, subtract if it fits
  // ---------------------------------------------------------------------------
  logic [HLEN_W:0]   div_trial;
  logic [HLEN_W:0]   div_diff;
  logic              div_fit;
  logic [HLEN_W-1:0] rem_nxt;

  assign div_trial = {rem_q, acc_q[SUM_W-1]};
  assign div_diff  = div_trial - {1'b0, hlen_q};
  assign div_fit   = (div_trial >= {1'b0, hlen_q});
  assign rem_nxt   = div_fit ? div_diff[HLEN_W-1:0] : div_trial[HLEN_W-1:0];

  // ---------------------------------------------------------------------------
  // Time checks, modulo 2^48
  // ---------------------------------------------------------------------------
  logic [TIME_W-1:0] since_touch;
  logic [TIME_W-1:0] since_boost;
  logic              hold_hit;

  assign since_touch = now_q - last_touch_q;
  assign since_boost = now_q - last_boost_q;
  assign hold_hit    = (since_touch < TIME_W'(hold_us_q));

  // ---------------------------------------------------------------------------
  // Table row under test
  // ---------------------------------------------------------------------------
  logic [TBL_W-1:0] lvl_up;
  logic [TBL_W-1:0] lvl_dn;
  logic             row_end;
  logic             row_hit;

  assign lvl_up  = level_up(row_q);
  assign lvl_dn  = level_down(row_q);
  assign row_end = (lvl_up == '0);
  assign row_hit = (avg_q <= LOAD_W'(lvl_up)) && (avg_q > LOAD_W'(lvl_dn));

  // ---------------------------------------------------------------------------
  // Touch decision
  // ---------------------------------------------------------------------------
  logic    tch_boost;
  action_e tch_act;

  always_comb begin
    tch_boost = (since_boost >= TOUCH_GAP_US) && (online_q < boost_q) && (boost_q > min_q);
    tch_act   = ACT_NONE;
    if (tch_boost && en_q && (boost_q > online_q) && (online_q < max_q)) begin
      tch_act = ACT_UP;
    end
  end

  // ---------------------------------------------------------------------------
  // Sample decision: fast lane, locked counts, then the clamped table target
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] tbl_clamp;
  logic [CNT_W-1:0] cand;
  logic             want_up;
  logic             want_dn;
  action_e          dec_act;

  always_comb begin
    if (CNT_W'(tbl_tgt_q) > max_q) begin
      tbl_clamp = max_q;
    end else if (CNT_W'(tbl_tgt_q) < min_q) begin
      tbl_clamp = min_q;
    end else begin
      tbl_clamp = CNT_W'(tbl_tgt_q);
    end

    want_up = 1'b0;
    want_dn = 1'b0;
    if (LEVEL_W'(peak_q) >= flane_q) begin
      cand    = max_q;
      want_up = 1'b1;
    end else if ({1'b0, min_q} == CORE_LIMIT) begin
      cand    = min_q;
      want_up = (online_q != min_q);
    end else if (max_q == CNT_W'(1)) begin
      cand    = max_q;
      want_dn = (online_q != max_q);
    end else begin
      cand    = tbl_clamp;
      want_up = (tbl_clamp > online_q);
      want_dn = (tbl_clamp < online_q);
    end

    dec_act = ACT_NONE;
    if (want_up && en_q && (cand > online_q) && (online_q < max_q)) begin
      dec_act = ACT_UP;
    end else if (want_dn && en_q && (cand < online_q) && (online_q > min_q) &&
                 !((online_q <= boost_q) && hold_q)) begin
      dec_act = ACT_DOWN;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (kind_i == KIND_TOUCH) ? ST_TOUCH : ST_SAMPLE;
        end
      end
      ST_TOUCH:  state_d = ST_EMIT;
      ST_SAMPLE: state_d = hist_on ? ST_READ : ST_TABLE;
      ST_READ: begin
        if (!rd_en && !pend_q) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (dcnt_q == DCNT_W'(1)) begin
          state_d = ST_TABLE;
        end
      end
      ST_TABLE: begin
        if (row_end || row_hit) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: state_d = ST_EMIT;
      ST_EMIT: begin
        if (emit_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control and governor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      en_q         <= 1'b1;
      min_q        <= MIN_ONLINE_RESET;
      max_q        <= MAX_RST;
      boost_q      <= BOOST_CNT_RESET;
      flane_q      <= FAST_LANE_RESET;
      hold_us_q    <= BOOST_HOLD_RESET;
      hlen_q       <= HLEN_RST;
      pos_q        <= '0;
      avg_q        <= '0;
      last_touch_q <= '0;
      last_boost_q <= '0;
      ring_vld_q   <= '0;
      idx_q        <= '0;
      pend_q       <= 1'b0;
      dcnt_q       <= '0;
      row_q        <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q <= state_d;

      // Register writes; out-of-range counts and lengths are dropped
      if (cfg_we) begin
        case (cfg_index_i)
          REG_ENABLED: en_q <= cfg_data_i[0];
          REG_MIN_ONLINE: begin
            if ((cfg_data_i[CNT_W-1:0] != '0) &&
                ({1'b0, cfg_data_i[CNT_W-1:0]} <= CORE_LIMIT)) begin
              min_q <= cfg_data_i[CNT_W-1:0];
              if (max_q < cfg_data_i[CNT_W-1:0]) begin
                max_q <= cfg_data_i[CNT_W-1:0];
              end
            end
          end
          REG_MAX_ONLINE: begin
            if ((cfg_data_i[CNT_W-1:0] != '0) &&
                ({1'b0, cfg_data_i[CNT_W-1:0]} <= CORE_LIMIT)) begin
              max_q <= cfg_data_i[CNT_W-1:0];
              if (min_q > cfg_data_i[CNT_W-1:0]) begin
                min_q <= cfg_data_i[CNT_W-1:0];
              end
            end
          end
          REG_BOOST_CNT: begin
            if ((cfg_data_i[CNT_W-1:0] != '0) &&
                ({1'b0, cfg_data_i[CNT_W-1:0]} <= CORE_LIMIT)) begin
              boost_q <= cfg_data_i[CNT_W-1:0];
            end
          end
          REG_FAST_LANE:  flane_q   <= cfg_data_i[LEVEL_W-1:0];
          REG_BOOST_HOLD: hold_us_q <= cfg_data_i[HOLD_W-1:0];
          REG_HIST_LEN: begin
            if ((cfg_data_i[HLEN_W-1:0] != '0) &&
                (CMP_W'(cfg_data_i[HLEN_W-1:0]) <= HIST_LIMIT)) begin
              hlen_q <= cfg_data_i[HLEN_W-1:0];
            end
          end
          default: ;
        endcase
      end

      case (state_q)
        ST_TOUCH: begin
          // Record the touch; a boost refused only by the enable or the
          // ceiling still restarts the boost spacing
          last_touch_q <= now_q;
          if (tch_boost) begin
            last_boost_q <= now_q;
          end
        end
        ST_SAMPLE: begin
          idx_q  <= '0;
          pend_q <= 1'b0;
          row_q  <= ROW_W'(1);
          if (hist_on) begin
            ring_vld_q[pos_eff] <= 1'b1;
            pos_q               <= pos_nxt;
          end else begin
            avg_q <= total_q;
          end
        end
        ST_READ: begin
          pend_q <= rd_en;
          if (rd_en) begin
            idx_q <= idx_q + CMP_W'(1);
          end
          if (!rd_en && !pend_q) begin
            dcnt_q <= DIV_STEPS;
          end
        end
        ST_DIV: begin
          dcnt_q <= dcnt_q - DCNT_W'(1);
          if (dcnt_q == DCNT_W'(1)) begin
            // Quotient is complete once the last bit shifts in
            avg_q <= LOAD_W'({acc_q[SUM_W-2:0], div_fit});
          end
        end
        ST_TABLE: begin
          if (!row_end && !row_hit) begin
            row_q <= row_q + ROW_W'(1);
          end
        end
        default: ;
      endcase

      // Result register: drop when taken, load when the sequencer finishes
      if (emit_go) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q   <= kind_i;
      total_q  <= total_load_i;
      peak_q   <= peak_load_i;
      online_q <= cores_online_i;
      now_q    <= now_us_i;
    end

    rd_vld_q <= ring_vld_q[ram_raddr];

    case (state_q)
      ST_TOUCH: begin
        res_act_q <= tch_act;
        res_tgt_q <= (tch_act == ACT_NONE) ? '0 : boost_q;
      end
      ST_SAMPLE: begin
        acc_q     <= '0;
        tbl_tgt_q <= '0;
        hold_q    <= hold_hit;
      end
      ST_READ: begin
        if (pend_q) begin
          acc_q <= acc_q + SUM_W'(rd_load);
        end
        rem_q <= '0;
      end
      ST_DIV: begin
        rem_q <= rem_nxt;
        acc_q <= {acc_q[SUM_W-2:0], div_fit};
      end
      ST_TABLE: begin
        if (!row_end && row_hit) begin
          tbl_tgt_q <= row_q;
        end
      end
      ST_DECIDE: begin
        res_act_q <= dec_act;
        res_tgt_q <= (dec_act == ACT_NONE) ? '0 : cand;
      end
      default: ;
    endcase

    if (emit_go) begin
      out_act_q <= res_act_q;
      out_tgt_q <= res_tgt_q;
      out_avg_q <= avg_q;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign action_o       = out_act_q;
  assign target_cores_o = out_tgt_q;
  assign avg_load_o     = out_avg_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_min_le_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    min_q <= max_q)
    else $error("min_online above max_online");

  a_none_no_target : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (action_o == ACT_NONE)) |-> (target_cores_o == '0))
    else $error("target given with no action");

  a_rem_below_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < hlen_q))
    else $error("divider remainder not below history length");

  a_read_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> (idx_q <= len_ext))
    else $error("history read ran past history length");

  a_result_from_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> ($past(state_q) == ST_EMIT))
    else $error("result raised outside the emit step");

  a_target_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, target_cores_o} <= CORE_LIMIT))
    else $error("target above core count");

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the core count governor.
// A directed script runs first, then eight phases of random traffic, each opened
// by a full set of register writes. Every accepted input beat is run through a
// behavioural predictor of the governor. The predicted decision is queued, and
// each result beat is compared against the head of that queue.
module tb_top;
  import cgov_pkg::*;

  localparam int unsigned CORE_N = CGOV_CORE_COUNT;
  localparam int unsigned HIST_N = CGOV_HIST_MAX;

  // Idle cycles with no handshake on any channel before the run is abandoned
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  // Settling time after the last result
  localparam int unsigned TAIL_CYCLES = 60;

  // Register index with nothing behind it; a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  localparam logic [TIME_W-1:0] TIME_TOP = '1;
  localparam logic [HOLD_W-1:0] HOLD_TOP = '1;

  // Threshold rows (upper, lower) per core count; a zero upper level ends the walk
  localparam int unsigned LVL_UP [0:5] = '{400, 65, 120, 190, 410, 0};
  localparam int unsigned LVL_DN [0:5] = '{0, 0, 50, 100, 170, 0};

  typedef struct {
    action_e           act;
    logic [CNT_W-1:0]  tgt;
    logic [LOAD_W-1:0] avg;
  } decision_t;

  // One line of stimulus: either a register write or an input beat
  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    logic                  kind;
    logic [LOAD_W-1:0]     total;
    logic [PEAK_W-1:0]     peak;
    logic [CNT_W-1:0]      online;
    logic [TIME_W-1:0]     now;
    bit                    typed;
    decision_t             want;
  } step_t;

  typedef enum int {RX_FREE, RX_COIN, RX_COMB, RX_CHOKE} rx_mode_e;

  // ---------------------------------------------------------------------------
  // DUT signals; the driven ones are known from time zero
  // ---------------------------------------------------------------------------
  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_valid_i    = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i     = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_stall_o;
  logic                  kind_i         = KIND_SAMPLE;
  logic [LOAD_W-1:0]     total_load_i   = '0;
  logic [PEAK_W-1:0]     peak_load_i    = '0;
  logic [CNT_W-1:0]      cores_online_i = 4'd1;
  logic [TIME_W-1:0]     now_us_i       = '0;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic [1:0]            action_o;
  logic [CNT_W-1:0]      target_cores_o;
  logic [LOAD_W-1:0]     avg_load_o;

  core_count_governor_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .total_load_i   (total_load_i),
    .peak_load_i    (peak_load_i),
    .cores_online_i (cores_online_i),
    .now_us_i       (now_us_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .action_o       (action_o),
    .target_cores_o (target_cores_o),
    .avg_load_o     (avg_load_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Governor predictor: own copy of the registers and the history
  // ---------------------------------------------------------------------------
  logic              gov_on;
  int unsigned       min_on, max_on, boost_cnt, fast_lvl, hist_len;
  logic [HOLD_W-1:0] hold_us;
  logic [LOAD_W-1:0] hist_ring [HIST_N];
  int unsigned       ring_at;
  logic [LOAD_W-1:0] load_avg;
  logic [TIME_W-1:0] last_touch_at, last_boost_at;

  // Decisions still owed by the DUT, oldest first
  decision_t pending_decisions [$];

  int unsigned n_errors, n_checked, n_samples, n_touches, n_writes;
  int unsigned n_up, n_down, n_idle;

  task automatic report_mismatch(input string what);
    if (n_errors < 50) $display("%0t ERROR: %s", $time, what);
    n_errors++;
  endtask

  // Mirror a register write, including the range filter and min/max coupling
  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    int unsigned v;
    v = data[7:0];
    case (idx)
      REG_ENABLED: gov_on = data[0];
      REG_MIN_ONLINE: begin
        v = v & 'hF;
        if (v >= 1 && v <= CORE_N) begin
          if (max_on < v) max_on = v;
          min_on = v;
        end
      end
      REG_MAX_ONLINE: begin
        v = v & 'hF;
        if (v >= 1 && v <= CORE_N) begin
          if (min_on > v) min_on = v;
          max_on = v;
        end
      end
      REG_BOOST_CNT: begin
        v = v & 'hF;
        if (v >= 1 && v <= CORE_N) boost_cnt = v;
      end
      REG_FAST_LANE:  fast_lvl = v;
      REG_BOOST_HOLD: hold_us = data[HOLD_W-1:0];
      REG_HIST_LEN: begin
        v = v & 'h1F;
        if (v >= 1 && v <= HIST_N) hist_len = v;
      end
      default: ;
    endcase
  endfunction

  function automatic void ask_more(input int unsigned want, input int unsigned online,
                                   inout decision_t d);
    if (gov_on && want > online && online < max_on) begin
      d.act = ACT_UP;
      d.tgt = CNT_W'(want);
    end
  endfunction

  function automatic void ask_fewer(input int unsigned want, input int unsigned online,
                                    input logic [TIME_W-1:0] now, inout decision_t d);
    logic [TIME_W-1:0] since;
    since = now - last_touch_at;
    // take-down below the boost count is held off for a while after touch
    if (gov_on && want < online && online > min_on &&
        !(online <= boost_cnt && since < hold_us)) begin
      d.act = ACT_DOWN;
      d.tgt = CNT_W'(want);
    end
  endfunction

  function automatic decision_t decide(input logic kind, input logic [LOAD_W-1:0] total,
                                       input logic [PEAK_W-1:0] peak,
                                       input logic [CNT_W-1:0] online_in,
                                       input logic [TIME_W-1:0] now);
    decision_t         d;
    int unsigned       sum, tgt, online, i;
    bit                hit;
    logic [TIME_W-1:0] since;
    d.act  = ACT_NONE;
    d.tgt  = '0;
    online = online_in;
    if (kind == KIND_SAMPLE) begin
      if (hist_len <= 1) begin
        load_avg = total;
      end else begin
        if (ring_at >= hist_len) ring_at = 0;
        hist_ring[ring_at] = total;
        sum = 0;
        for (i = 0; i < hist_len; i++) sum += hist_ring[i];
        ring_at++;
        if (ring_at >= hist_len) ring_at = 0;
        load_avg = LOAD_W'(sum / hist_len);
      end
      if (peak >= fast_lvl) begin
        ask_more(max_on, online, d);
      end else if (min_on == CORE_N) begin
        if (online != min_on) ask_more(min_on, online, d);
      end else if (max_on == 1) begin
        if (online != max_on) ask_fewer(max_on, online, now, d);
      end else begin
        tgt = 0;
        hit = 1'b0;
        for (i = 1; i < 6 && LVL_UP[i] != 0; i++) begin
          if (!hit && load_avg <= LVL_UP[i] && load_avg > LVL_DN[i]) begin
            tgt = i;
            hit = 1'b1;
          end
        end
        if (tgt > max_on) tgt = max_on;
        else if (tgt < min_on) tgt = min_on;
        if (tgt > online) ask_more(tgt, online, d);
        else if (tgt < online) ask_fewer(tgt, online, now, d);
      end
    end else begin
      last_touch_at = now;
      since = now - last_boost_at;
      if (since >= TOUCH_GAP_US && online < boost_cnt && boost_cnt > min_on) begin
        ask_more(boost_cnt, online, d);
        // stamp the boost even when the request itself is refused
        last_boost_at = now;
      end
    end
    d.avg = load_avg;
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed script
  // ---------------------------------------------------------------------------
  step_t script [$];

  function automatic void put_item(input logic kind, input int unsigned total,
                                   input int unsigned peak, input int unsigned online,
                                   input logic [TIME_W-1:0] now);
    step_t s;
    s        = '{default: '0};
    s.kind   = kind;
    s.total  = LOAD_W'(total);
    s.peak   = PEAK_W'(peak);
    s.online = CNT_W'(online);
    s.now    = now;
    s.want   = '{ACT_NONE, '0, '0};
    script.push_back(s);
  endfunction

  // Same as put_item, but with the outcome written down by hand
  function automatic void put_typed(input logic kind, input int unsigned total,
                                    input int unsigned peak, input int unsigned online,
                                    input logic [TIME_W-1:0] now, input action_e act,
                                    input int unsigned tgt, input int unsigned avg);
    put_item(kind, total, peak, online, now);
    script[$].typed = 1'b1;
    script[$].want  = '{act, CNT_W'(tgt), LOAD_W'(avg)};
  endfunction

  function automatic void put_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    step_t s;
    s          = '{default: '0};
    s.is_cfg   = 1'b1;
    s.reg_idx  = idx;
    s.reg_data = data;
    s.want     = '{ACT_NONE, '0, '0};
    script.push_back(s);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  int unsigned burst_left;

  // Present one beat and hold it until taken; valid stays high on return
  task automatic send_beat(input step_t s);
    decision_t d;
    kind_i         <= s.kind;
    total_load_i   <= s.total;
    peak_load_i    <= s.peak;
    cores_online_i <= s.online;
    now_us_i       <= s.now;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    d = decide(s.kind, s.total, s.peak, s.online, s.now);
    if (s.typed) d = s.want;
    pending_decisions.push_back(d);
    if (s.kind == KIND_SAMPLE) n_samples++;
    else n_touches++;
    case (d.act)
      ACT_UP:   n_up++;
      ACT_DOWN: n_down++;
      default:  n_idle++;
    endcase
  endtask

  // Drop valid and hold off until every owed result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_decisions.size() != 0);
  endtask

  // Register writes only go in with the block empty
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    drain();
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    apply_reg(idx, data);
    n_writes++;
  endtask

  // Bursts of back-to-back beats separated by gaps of random length
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 8);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [TIME_W-1:0] clock_us;
    int unsigned       online_now, load_base, mn, mx, r;
    int                lvl;
    step_t             s;

    gov_on        = 1'b1;
    min_on        = MIN_ONLINE_RESET;
    max_on        = MAX_ONLINE_RESET;
    boost_cnt     = BOOST_CNT_RESET;
    fast_lvl      = FAST_LANE_RESET;
    hold_us       = BOOST_HOLD_RESET;
    hist_len      = HIST_LEN_RESET;
    foreach (hist_ring[i]) hist_ring[i] = '0;
    ring_at       = 0;
    load_avg      = '0;
    last_touch_at = '0;
    last_boost_at = '0;
    burst_left    = 0;

    // Reset defaults, empty history, first touch boosts and the hold-off
    put_typed(KIND_SAMPLE,   0,   0, 1,    1_000, ACT_NONE, 0,   0);
    put_typed(KIND_SAMPLE, 800, 100, 1,    2_000, ACT_UP,   8,  80);
    put_typed(KIND_SAMPLE, 800,  99, 8,    3_000, ACT_NONE, 0, 160);
    put_typed(KIND_TOUCH,    0,   0, 1,    4_000, ACT_NONE, 0, 160);
    put_typed(KIND_TOUCH,    0,   0, 2,  200_000, ACT_UP,   4, 160);
    put_typed(KIND_TOUCH,    0,   0, 1,  300_000, ACT_NONE, 0, 160);
    put_typed(KIND_SAMPLE,   0,   0, 8,  400_000, ACT_DOWN, 3, 160);
    put_typed(KIND_SAMPLE,   0,   0, 4,  500_000, ACT_NONE, 0, 160);
    put_typed(KIND_SAMPLE, 800,   0, 1,  600_000, ACT_UP,   4, 240);
    // history of one: the sample is the average, ring left alone
    put_cfg(REG_HIST_LEN, 40'd1);
    put_typed(KIND_SAMPLE, 700,   0, 8,  700_000, ACT_DOWN, 1, 700);
    // shorter history leaves the ring position stale
    put_cfg(REG_HIST_LEN, 40'd3);
    put_item(KIND_SAMPLE,   30,   0, 2,  800_000);
    put_cfg(REG_HIST_LEN, 40'd16);
    put_item(KIND_SAMPLE,  410,   0, 4,  900_000);
    // zero and oversized lengths are ignored; only the low five bits count
    put_cfg(REG_HIST_LEN, 40'd0);
    put_cfg(REG_HIST_LEN, 40'd17);
    put_cfg(REG_HIST_LEN, 40'h21);
    put_item(KIND_SAMPLE,   51,   0, 1, 1_000_000);
    put_item(KIND_SAMPLE,   66,   0, 1, 1_100_000);
    put_item(KIND_SAMPLE,  410,   0, 2, 1_200_000);
    put_item(KIND_SAMPLE,  411,   0, 3, 1_300_000);
    // locked counts, with min and max dragging each other along
    put_cfg(REG_MIN_ONLINE, 40'd8);
    put_item(KIND_SAMPLE,  100,   0, 3, 1_400_000);
    put_cfg(REG_MAX_ONLINE, 40'd1);
    put_item(KIND_SAMPLE,  100,   0, 5, 1_500_000);
    put_item(KIND_SAMPLE,  100,   0, 3, 1_600_000);
    put_cfg(REG_MAX_ONLINE, 40'd0);
    put_cfg(REG_MIN_ONLINE, 40'd9);
    put_cfg(REG_BOOST_CNT, 40'd15);
    put_cfg(REG_UNMAPPED, 40'd5);
    put_cfg(REG_MAX_ONLINE, 40'd8);
    put_cfg(REG_BOOST_CNT, 40'd8);
    put_cfg(REG_FAST_LANE, 40'd0);
    put_item(KIND_SAMPLE,    0,   0, 2, 1_700_000);
    // disabled governor still stamps the boost time
    put_cfg(REG_ENABLED, 40'd0);
    put_item(KIND_TOUCH,     0,   0, 1, 2_000_000);
    put_cfg(REG_ENABLED, 40'd1);
    put_cfg(REG_FAST_LANE, 40'd255);
    put_cfg(REG_BOOST_HOLD, HOLD_TOP);
    put_item(KIND_SAMPLE,    0,   0, 6, 3_000_000);
    put_cfg(REG_BOOST_HOLD, 40'd0);
    put_cfg(REG_BOOST_CNT, 40'd1);
    put_item(KIND_TOUCH,     0,   0, 1, 3_500_000);
    // boost spacing across the wrap of the time counter
    put_cfg(REG_BOOST_CNT, 40'd4);
    put_item(KIND_TOUCH,   800, 100, 2, TIME_TOP - 48'd99_999);
    put_item(KIND_TOUCH,     0,   0, 2, 48'd20_000);
    put_item(KIND_TOUCH,     0,   0, 3, 48'd60_000);

    // Hold reset, then release it on a clock edge
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[k]) begin
      if (script[k].is_cfg) begin
        write_reg(script[k].reg_idx, script[k].reg_data);
      end else begin
        send_beat(script[k]);
        pace();
      end
    end

    // Random phases: each opens with every register written, extremes on a few
    clock_us   = 48'd60_000;
    online_now = 1;
    load_base  = 150;
    for (int ph = 0; ph < 8; ph++) begin
      mn = (ph == 4) ? CORE_N : $urandom_range(1, 4);
      mx = (ph == 5) ? 1 : (ph == 2 || ph == 4) ? CORE_N : $urandom_range(mn, CORE_N);
      write_reg(REG_ENABLED, (ph == 3) ? 40'd0 : 40'd1);
      write_reg(REG_MIN_ONLINE, CFG_DATA_W'(mn));
      write_reg(REG_MAX_ONLINE, CFG_DATA_W'(mx));
      write_reg(REG_BOOST_CNT, CFG_DATA_W'($urandom_range(1, CORE_N)));
      write_reg(REG_FAST_LANE, (ph == 6) ? 40'd0 : (ph == 2) ? 40'd255 :
                ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 255))
                                            : CFG_DATA_W'($urandom_range(85, 100)));
      write_reg(REG_BOOST_HOLD, (ph == 1) ? 40'd0 : (ph == 2) ? HOLD_TOP :
                CFG_DATA_W'($urandom_range(0, 5_000_000)));
      write_reg(REG_HIST_LEN, (ph == 1) ? CFG_DATA_W'(HIST_N) : (ph == 2) ? 40'd1 :
                CFG_DATA_W'($urandom_range(1, HIST_N)));
      // jump close to the top of the time range so this phase wraps round
      if (ph == 5) clock_us = TIME_TOP - 48'd4_000_000;

      for (int n = 0; n < 100; n++) begin
        s = '{default: '0};
        s.want = '{ACT_NONE, '0, '0};
        s.kind = ($urandom_range(0, 99) < 12) ? KIND_TOUCH : KIND_SAMPLE;
        r = $urandom_range(0, 99);
        if (r < 15) clock_us += TIME_W'($urandom_range(0, 160_000));
        else if (r < 85) clock_us += TIME_W'($urandom_range(90_000, 110_000));
        else clock_us += TIME_W'($urandom_range(110_000, 4_000_000));
        s.now = clock_us;
        // load drifts around a level so the average walks the threshold rows
        if ($urandom_range(0, 19) == 0) load_base = $urandom_range(0, 480);
        if ($urandom_range(0, 99) < 15) begin
          s.total = LOAD_W'($urandom_range(0, 800));
        end else begin
          lvl = int'(load_base) + $urandom_range(0, 120) - 60;
          if (lvl < 0) lvl = 0;
          s.total = LOAD_W'(lvl);
        end
        s.peak = ($urandom_range(0, 3) == 0) ? PEAK_W'($urandom_range(0, 100))
                                             : PEAK_W'($urandom_range(0, 80));
        if ($urandom_range(0, 9) < 4) online_now = $urandom_range(1, CORE_N);
        s.online = CNT_W'(online_now);
        send_beat(s);
        if ($urandom_range(0, 59) == 0) drain();
        else pace();
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_decisions.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_decisions.size()));

    $display("Covered %0d load samples and %0d touch beats across %0d register writes",
             n_samples, n_touches, n_writes);
    $display("Checked %0d results: %0d bring-up, %0d take-down, %0d no action",
             n_checked, n_up, n_down, n_idle);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver side: stall pattern, result check and watchdog
  // ---------------------------------------------------------------------------
  rx_mode_e    rx_mode    = RX_FREE;
  int unsigned rx_left    = 0;
  int unsigned rx_tick    = 0;
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    decision_t d;
    logic      moved;
    // switch stall behaviour at random intervals, free-running stretches too
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(40, 400);
    end else begin
      rx_left--;
    end
    rx_tick++;
    case (rx_mode)
      RX_FREE:  out_stall_i <= 1'b0;
      RX_COIN:  out_stall_i <= 1'($urandom_range(0, 1));
      RX_COMB:  out_stall_i <= (rx_tick % 7) < 3;
      default:  out_stall_i <= ($urandom_range(0, 11) != 0);
    endcase

    if (rst_ni) begin
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        if (pending_decisions.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          d = pending_decisions.pop_front();
          n_checked++;
          if (action_o !== d.act)
            report_mismatch($sformatf("result %0d: action %0d, expected %0d",
                                      n_checked, action_o, d.act));
          if (target_cores_o !== d.tgt)
            report_mismatch($sformatf("result %0d: target %0d, expected %0d",
                                      n_checked, target_cores_o, d.tgt));
          if (avg_load_o !== d.avg)
            report_mismatch($sformatf("result %0d: avg load %0d, expected %0d",
                                      n_checked, avg_load_o, d.avg));
        end
      end

      // any beat on any channel counts as progress
      moved = (in_valid_i & ~in_stall_o) | (out_valid_o & ~out_stall_i) |
              (cfg_valid_i & cfg_ready_o);
      quiet_cycles = (moved === 1'b1) ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no handshake for %0d cycles", $time, quiet_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

endmodule
